// ===== rtl/twgas_pkg.sv =====
// ----------------------------------------------------------------------------
// twgas_pkg
// shared widths, item codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package twgas_pkg;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int INVAL_W = 32;
    localparam int CFG_W   = 11;
    localparam int EPOCH_W = 32;
    localparam int SUM_W   = 43;
    localparam int OUT_W   = 42;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_POINT = 2'd1,
        MODE_ALL   = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic accept;
        logic load_do;
        logic point_do;
        logic mul_do;
        logic all_do;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/twgas_ctrl.sv =====
// ----------------------------------------------------------------------------
// twgas_ctrl
// sequencer: accepts one word at a time and steps the datapath through it
// ----------------------------------------------------------------------------
module twgas_ctrl
    import twgas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    input  t_sts              i_sts,
    output logic              o_in_ready,
    output t_cmd              o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_RMW  = 5'b00100,
        S_MUL  = 5'b01000,
        S_ALL  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (t_mode'(i_mode))
                        MODE_LOAD:  n_state = S_LOAD;
                        MODE_POINT: n_state = S_RMW;
                        MODE_ALL:   n_state = S_MUL;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load_do = 1'b1;
                n_state       = S_IDLE;
            end
            S_RMW: begin
                if (i_sts.out_free) begin
                    o_cmd.point_do = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul_do = 1'b1;
                n_state      = S_ALL;
            end
            S_ALL: begin
                if (i_sts.out_free) begin
                    o_cmd.all_do = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/twgas_dp.sv =====
// ----------------------------------------------------------------------------
// twgas_dp
// table memory with epoch tags, global value, running sum and result register
// ----------------------------------------------------------------------------
module twgas_dp
    import twgas_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [CFG_W-1:0]   i_entries_in_use,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [INVAL_W-1:0] i_new_value,
    input  logic               i_out_ready,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic [OUT_W-1:0]   o_table_sum
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW  = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int NW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int XW  = (VALUE_WIDTH > INVAL_W) ? VALUE_WIDTH : INVAL_W;
    localparam int MW  = VALUE_WIDTH + EPOCH_W;
    localparam int PW0 = VALUE_WIDTH + NW;
    localparam int PW  = (PW0 > SUM_W) ? PW0 : SUM_W;

    logic [MW-1:0] r_mem [TABLE_DEPTH];
    logic [MW-1:0] r_rd;

    logic [CFG_W-1:0]       r_entries_in_use;
    logic [VALUE_WIDTH-1:0] r_global;
    logic [EPOCH_W-1:0]     r_epoch;
    logic [SUM_W-1:0]       r_sum;
    logic [INDEX_W-1:0]     r_idx;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_hit;
    logic [SUM_W-1:0]       r_prod;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_sum;

    logic [NW-1:0]          w_used;
    logic [NW-1:0]          w_cfg_ext;
    logic [IW-1:0]          w_rd_idx_ext;
    logic [IW-1:0]          w_wr_idx_ext;
    logic [XW-1:0]          w_val_ext;
    logic [VALUE_WIDTH-1:0] w_old;
    logic [SUM_W-1:0]       w_point_sum;
    logic [PW-1:0]          w_prod;
    logic                   w_wr_en;

    // entries in use, saturated at the table depth
    assign w_cfg_ext    = NW'(r_entries_in_use);
    assign w_used       = (w_cfg_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : w_cfg_ext;
    assign w_rd_idx_ext = IW'(i_entry_index);
    assign w_wr_idx_ext = IW'(r_idx);
    assign w_val_ext    = XW'(i_new_value);

    // stale tag reads as the global value
    assign w_old       = (r_rd[MW-1 -: EPOCH_W] == r_epoch) ? r_rd[VALUE_WIDTH-1:0] : r_global;
    assign w_point_sum = r_hit ? (r_sum - SUM_W'(w_old) + SUM_W'(r_val)) : r_sum;
    assign w_prod      = PW'(r_val) * PW'(w_used);
    assign w_wr_en     = r_hit && (i_cmd.load_do || i_cmd.point_do);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx_ext[AW-1:0]] <= {r_epoch, r_val};
        end
        if (i_cmd.accept) begin
            r_rd <= r_mem[w_rd_idx_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= i_entry_index;
            r_val <= w_val_ext[VALUE_WIDTH-1:0];
            r_hit <= (NW'(i_entry_index) < w_used);
        end
        if (i_cmd.mul_do) begin
            r_prod <= w_prod[SUM_W-1:0];
        end
        if (i_cmd.point_do) begin
            r_out_sum <= w_point_sum[OUT_W-1:0];
        end else if (i_cmd.all_do) begin
            r_out_sum <= r_prod[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= CFG_W'(1024);
            r_global         <= '0;
            r_epoch          <= '0;
            r_sum            <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entries_in_use <= i_entries_in_use;
            end
            if (i_cmd.load_do && r_hit) begin
                r_sum <= r_sum + SUM_W'(r_val);
            end else if (i_cmd.point_do) begin
                r_sum <= w_point_sum;
            end else if (i_cmd.all_do) begin
                r_sum    <= r_prod;
                r_global <= r_val;
                r_epoch  <= r_epoch + EPOCH_W'(1);
            end
            if (i_cmd.point_do || i_cmd.all_do) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_table_sum    = r_out_sum;

endmodule

// ===== rtl/table_with_global_assign_and_sum_top.sv =====
// ----------------------------------------------------------------------------
// table_with_global_assign_and_sum_top
// table with point assign, lazy assign-all and a running sum of its entries
//
//  channel  direction  handshake                   payload
//  cfg      in         i_cfg_valid / o_cfg_ready   i_entries_in_use
//  in       in         i_in_valid  / o_in_ready    i_mode, i_entry_index, i_new_value
//  out      out        o_out_valid / i_out_ready   o_table_sum
//
// point assign does a registered table read, then the update; assign-all
// registers the multiply by entries in use before it is committed
// one result may wait in the output register while the next word is taken
// a finished assign stalls only while that register is still full
// synchronous active-low reset; table contents are not cleared, no sweep
// ----------------------------------------------------------------------------
module table_with_global_assign_and_sum_top
    import twgas_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_entries_in_use,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [INVAL_W-1:0] i_new_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OUT_W-1:0]   o_table_sum
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    twgas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    twgas_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_entries_in_use (i_entries_in_use),
        .i_entry_index    (i_entry_index),
        .i_new_value      (i_new_value),
        .i_out_ready      (i_out_ready),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_table_sum      (o_table_sum)
    );

endmodule
